// ----- sv/normalized_preamble_correlator_assert.svh -----
// Assertion macros shared by the correlator modules.
// Needs i_clk and i_rst_n in the scope that uses them.
`ifndef NORMALIZED_PREAMBLE_CORRELATOR_ASSERT_SVH
`define NORMALIZED_PREAMBLE_CORRELATOR_ASSERT_SVH

// same-cycle implication
`define NPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("npc assertion failed");

// next-cycle implication
`define NPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("npc assertion failed");

`endif

// ----- sv/npc_pkg.sv -----
// Shared types and constants of the normalized preamble correlator.
// No dependencies.
package npc_pkg;

    localparam int SMP_W    = 12;
    localparam int MAG_W    = 12;
    localparam int METRIC_W = 16;
    localparam int CFG_W    = 16;
    localparam int HOLD_W   = 18;
    localparam int COEF_W   = 16;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_LENGTH = 2'd1;

    localparam logic [CFG_W-1:0]  THRESHOLD_RST   = 16'd45875;
    localparam logic [CFG_W-1:0]  DATA_LENGTH_RST = 16'd256;
    localparam logic [HOLD_W-1:0] HOLD_MAX        = 18'd262143;

    // CORDIC gain-compensated start value (Q30) and arctangents in 2^-32 turn
    localparam int    CORDIC_STAGES = 30;
    localparam longint CORDIC_X0    = 64'sd652032874;
    localparam longint ATAN_TURNS [CORDIC_STAGES] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    typedef struct packed {
        logic accept;
        logic mag_step;
        logic update;
        logic mac_step;
        logic sq_init;
        logic sq_step;
        logic rt_init;
        logic rt_step;
        logic dv_init;
        logic dv_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_full;
    } t_dp_sts;

endpackage

// ----- sv/npc_if.sv -----
// Channel interfaces: sample input, result output, register writes.
// Depends on npc_pkg.
interface npc_in_if import npc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_i;
    logic signed [SMP_W-1:0] sample_q;
    modport source (output valid, output sample_i, output sample_q, input ready);
    modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface npc_out_if import npc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [METRIC_W-1:0]     metric;
    logic                    frame_start;
    logic signed [SMP_W-1:0] delayed_i;
    logic signed [SMP_W-1:0] delayed_q;
    modport source (output valid, output metric, output frame_start,
                    output delayed_i, output delayed_q, input ready);
    modport sink   (input valid, input metric, input frame_start,
                    input delayed_i, input delayed_q, output ready);
endinterface

interface npc_cfg_if import npc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/npc_dp.sv -----
// Datapath: sample/magnitude windows, chirp ROM, complex MAC, bit-serial
// square, digit sqrt, restoring divide, holdoff and output register.
// Depends on npc_pkg, npc_if and the assertion header.
`include "normalized_preamble_correlator_assert.svh"

module npc_dp import npc_pkg::*; #(
    parameter int SEQ_LEN = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  logic signed [SMP_W-1:0] i_sample_i,
    input  logic signed [SMP_W-1:0] i_sample_q,
    npc_cfg_if.sink                 i_cfg,
    npc_out_if.source               o_result
);

    localparam int LOG_N   = $clog2(SEQ_LEN);
    localparam int SUM_W   = MAG_W + LOG_N;
    localparam int PROD_W  = SMP_W + COEF_W;
    localparam int ACC_W   = PROD_W + 1 + LOG_N;
    localparam int RT_W    = ACC_W + 1;
    localparam int SQ_W    = 2 * RT_W;
    localparam int REM_W   = RT_W + 3;
    localparam int DVD_W   = RT_W + 2;
    localparam int CNT_MAX = (SEQ_LEN + 2 > DVD_W) ? SEQ_LEN + 2 : DVD_W;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    function automatic logic [2*COEF_W-1:0] chirp_coef(input int n);
        longint k, phase, z, x, y, dx, dy, c, s, nc, ns;
        longint quad;
        logic [2*COEF_W-1:0] res;
        k     = (longint'(n) * longint'(n + 1)) % (2 * SEQ_LEN);
        phase = (k <<< 31) / SEQ_LEN;
        quad  = phase >>> 30;
        z     = phase & 64'h3FFF_FFFF;
        x     = CORDIC_X0;
        y     = 0;
        for (int st = 0; st < CORDIC_STAGES; st++) begin
            dx = y >>> st;
            dy = x >>> st;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_TURNS[st];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_TURNS[st];
            end
        end
        c  = (x + 32768) >>> 16;
        s  = (y + 32768) >>> 16;
        nc = -c;
        ns = -s;
        case (quad)
            0:       res = {c[COEF_W-1:0], s[COEF_W-1:0]};
            1:       res = {ns[COEF_W-1:0], c[COEF_W-1:0]};
            2:       res = {nc[COEF_W-1:0], ns[COEF_W-1:0]};
            default: res = {s[COEF_W-1:0], nc[COEF_W-1:0]};
        endcase
        return res;
    endfunction

    function automatic logic [SEQ_LEN*2*COEF_W-1:0] build_rom();
        logic [SEQ_LEN*2*COEF_W-1:0] rom;
        rom = '0;
        for (int n = 0; n < SEQ_LEN; n++) begin
            rom[n*2*COEF_W +: 2*COEF_W] = chirp_coef(n);
        end
        return rom;
    endfunction

    localparam logic [SEQ_LEN*2*COEF_W-1:0] CHIRP_ROM = build_rom();

    // configuration
    logic [CFG_W-1:0] r_threshold, r_data_length;

    // window state
    logic [2*SMP_W-1:0] r_smem [SEQ_LEN];
    logic [MAG_W-1:0]   r_mmem [SEQ_LEN];
    logic [SUM_W-1:0]   r_sum;
    logic [LOG_N-1:0]   r_wp;
    logic [LOG_N:0]     r_fill;
    logic [HOLD_W-1:0]  r_hold;
    logic [CNT_W-1:0]   r_cnt;

    // per-item working registers
    logic signed [SMP_W-1:0] r_si, r_sq;
    logic [2*MAG_W-1:0]      r_sqv;
    logic [MAG_W-1:0]        r_mag, r_old_mag;
    logic                    r_old_v;
    logic [LOG_N-1:0]        r_ptr;
    logic [2*SMP_W-1:0]      r_x;
    logic                    r_xv, r_s1, r_s1_first, r_s2;
    logic signed [COEF_W-1:0] r_ci, r_cq;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [ACC_W-1:0]  r_re, r_im;
    logic [SQ_W-1:0]          r_mr, r_mi, r_sqacc;
    logic [ACC_W-1:0]         r_br, r_bi;
    logic [SQ_W-1:0]          r_rad;
    logic [REM_W-1:0]         r_rem;
    logic [RT_W-1:0]          r_cm;
    logic [DVD_W-1:0]         r_dvd;
    logic [SUM_W:0]           r_drem, r_den;
    logic [2*SMP_W-1:0]       r_dly;

    // output register
    logic                r_out_valid, r_tag;
    logic [METRIC_W-1:0] r_metric;
    logic [2*SMP_W-1:0]  r_out_dly;

    // combinational helpers
    logic signed [2*SMP_W-1:0] w_pii, w_pqq;
    logic [2*MAG_W-1:0]        w_sqv;
    logic [MAG_W-1:0]          w_trial;
    logic [2*MAG_W-1:0]        w_trial_sq;
    logic [LOG_N-1:0]          w_ptr_nxt, w_wp_nxt;
    logic                      w_issue;
    logic signed [SMP_W-1:0]   w_xi, w_xq;
    logic [REM_W-1:0]          w_rem_sh, w_rt_trial;
    logic [SUM_W+1:0]          w_dv_sh;
    logic [METRIC_W-1:0]       w_metric;
    logic                      w_tag;
    logic [HOLD_W-1:0]         w_hold_lim;
    logic [MAG_W-1:0]          w_old_mag;

    assign w_pii = i_sample_i * i_sample_i;
    assign w_pqq = i_sample_q * i_sample_q;
    assign w_sqv = (2*MAG_W)'(w_pii) + (2*MAG_W)'(w_pqq);

    assign w_trial    = r_mag | (MAG_W'(1) << (MAG_W'(MAG_W - 1) - MAG_W'(r_cnt)));
    assign w_trial_sq = w_trial * w_trial;

    assign w_ptr_nxt = (r_ptr == LOG_N'(SEQ_LEN - 1)) ? '0 : r_ptr + 1'b1;
    assign w_wp_nxt  = (r_wp == LOG_N'(SEQ_LEN - 1)) ? '0 : r_wp + 1'b1;
    assign w_issue   = i_cmd.mac_step && (r_cnt < CNT_W'(SEQ_LEN));

    // slots never written since reset read as zero
    assign w_xi = r_xv ? r_x[2*SMP_W-1:SMP_W] : '0;
    assign w_xq = r_xv ? r_x[SMP_W-1:0] : '0;
    assign w_old_mag = r_old_v ? r_old_mag : '0;

    // trial subtrahend is 4*root + 1
    assign w_rem_sh   = {r_rem[REM_W-3:0], r_rad[SQ_W-1:SQ_W-2]};
    assign w_rt_trial = {1'b0, r_cm, 2'b01};
    assign w_dv_sh    = {r_drem, r_dvd[DVD_W-1]};

    assign w_metric   = (|r_dvd[DVD_W-1:METRIC_W]) ? '1 : r_dvd[METRIC_W-1:0];
    assign w_hold_lim = HOLD_W'(SEQ_LEN) + HOLD_W'(r_data_length);
    assign w_tag      = (w_metric >= r_threshold) && (r_hold > w_hold_lim);

    always_comb begin
        o_sts.out_full = r_out_valid;
        o_sts.last     = (i_cmd.mag_step && r_cnt == CNT_W'(MAG_W - 1))
                      || (i_cmd.mac_step && r_cnt == CNT_W'(SEQ_LEN + 1))
                      || (i_cmd.sq_step  && r_cnt == CNT_W'(ACC_W - 1))
                      || (i_cmd.rt_step  && r_cnt == CNT_W'(RT_W - 1))
                      || (i_cmd.dv_step  && r_cnt == CNT_W'(DVD_W - 1));
    end

    assign i_cfg.ready        = 1'b1;
    assign o_result.valid     = r_out_valid;
    assign o_result.metric    = r_metric;
    assign o_result.frame_start = r_tag;
    assign o_result.delayed_i = r_out_dly[2*SMP_W-1:SMP_W];
    assign o_result.delayed_q = r_out_dly[SMP_W-1:0];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= THRESHOLD_RST;
            r_data_length <= DATA_LENGTH_RST;
            r_sum         <= '0;
            r_wp          <= '0;
            r_fill        <= '0;
            r_hold        <= '0;
            r_cnt         <= '0;
            r_s1          <= 1'b0;
            r_s2          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_THRESHOLD:   r_threshold   <= i_cfg.data;
                    CFG_DATA_LENGTH: r_data_length <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_cmd.accept || i_cmd.update || i_cmd.sq_init || i_cmd.rt_init
                    || i_cmd.dv_init) begin
                r_cnt <= '0;
            end else if (i_cmd.mag_step || i_cmd.mac_step || i_cmd.sq_step
                    || i_cmd.rt_step || i_cmd.dv_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.update) begin
                r_sum <= r_sum - SUM_W'(w_old_mag) + SUM_W'(r_mag);
                r_wp  <= w_wp_nxt;
                if (r_fill != (LOG_N+1)'(SEQ_LEN)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            r_s1 <= w_issue;
            r_s2 <= r_s1;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (w_tag) begin
                    r_hold <= '0;
                end else if (r_hold != HOLD_MAX) begin
                    r_hold <= r_hold + 1'b1;
                end
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_smem[r_wp] <= {r_si, r_sq};
            r_mmem[r_wp] <= r_mag;
        end
        if (i_cmd.accept) begin
            r_old_mag <= r_mmem[r_wp];
        end
        if (w_issue) begin
            r_x <= r_smem[r_ptr];
        end
    end

    // arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_si    <= i_sample_i;
            r_sq    <= i_sample_q;
            r_sqv   <= w_sqv;
            r_mag   <= '0;
            r_old_v <= {1'b0, r_wp} < r_fill;
        end
        if (i_cmd.mag_step && w_trial_sq <= r_sqv) begin
            r_mag <= w_trial;
        end
        if (i_cmd.update) begin
            r_ptr <= w_wp_nxt;
            r_re  <= '0;
            r_im  <= '0;
        end
        if (w_issue) begin
            r_ptr      <= w_ptr_nxt;
            r_xv       <= {1'b0, r_ptr} < r_fill;
            r_s1_first <= (r_cnt == '0);
            {r_ci, r_cq} <= CHIRP_ROM[r_cnt[LOG_N-1:0] * (2*COEF_W) +: 2*COEF_W];
        end
        if (r_s1) begin
            r_p0 <= w_xi * r_ci;
            r_p1 <= w_xq * r_cq;
            r_p2 <= w_xi * r_cq;
            r_p3 <= w_xq * r_ci;
            if (r_s1_first) begin
                r_dly <= {w_xi, w_xq};
            end
        end
        if (r_s2) begin
            r_re <= r_re + ACC_W'(r_p0) - ACC_W'(r_p1);
            r_im <= r_im + ACC_W'(r_p2) + ACC_W'(r_p3);
        end
        if (i_cmd.sq_init) begin
            r_br    <= r_re[ACC_W-1] ? ACC_W'(-r_re) : ACC_W'(r_re);
            r_bi    <= r_im[ACC_W-1] ? ACC_W'(-r_im) : ACC_W'(r_im);
            r_mr    <= SQ_W'(r_re[ACC_W-1] ? ACC_W'(-r_re) : ACC_W'(r_re));
            r_mi    <= SQ_W'(r_im[ACC_W-1] ? ACC_W'(-r_im) : ACC_W'(r_im));
            r_sqacc <= '0;
        end
        if (i_cmd.sq_step) begin
            r_sqacc <= r_sqacc + (r_br[0] ? r_mr : '0) + (r_bi[0] ? r_mi : '0);
            r_mr    <= r_mr << 1;
            r_mi    <= r_mi << 1;
            r_br    <= r_br >> 1;
            r_bi    <= r_bi >> 1;
        end
        if (i_cmd.rt_init) begin
            r_rad <= r_sqacc;
            r_rem <= '0;
            r_cm  <= '0;
        end
        if (i_cmd.rt_step) begin
            r_rad <= r_rad << 2;
            if (w_rem_sh >= w_rt_trial) begin
                r_rem <= w_rem_sh - w_rt_trial;
                r_cm  <= {r_cm[RT_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_cm  <= {r_cm[RT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.dv_init) begin
            r_dvd  <= {r_cm, 2'b00};
            r_drem <= '0;
            r_den  <= (SUM_W+1)'(r_sum) + 1'b1;
        end
        if (i_cmd.dv_step) begin
            if (w_dv_sh >= (SUM_W+2)'(r_den)) begin
                r_drem <= (SUM_W+1)'(w_dv_sh - (SUM_W+2)'(r_den));
                r_dvd  <= {r_dvd[DVD_W-2:0], 1'b1};
            end else begin
                r_drem <= w_dv_sh[SUM_W:0];
                r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_metric  <= w_metric;
            r_tag     <= w_tag;
            r_out_dly <= r_dly;
        end
    end

    `NPC_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= (LOG_N+1)'(SEQ_LEN))
    `NPC_ASSERT_NXT(a_tag_clears_hold, i_cmd.finish && w_tag, r_hold == '0)
    `NPC_ASSERT_NXT(a_metric_sat, i_cmd.finish && (|r_dvd[DVD_W-1:METRIC_W]), r_metric == '1)

endmodule

// ----- sv/npc_ctrl.sv -----
// Sequencer that walks each sample through the datapath phases.
// Depends on npc_pkg and the assertion header.
`include "normalized_preamble_correlator_assert.svh"

module npc_ctrl import npc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_MAG, S_UPD, S_MAC, S_SQI, S_SQR, S_RTI, S_RT, S_DVI, S_DV, S_FIN
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mag_step = (r_state == S_MAG);
        o_cmd.update   = (r_state == S_UPD);
        o_cmd.mac_step = (r_state == S_MAC);
        o_cmd.sq_init  = (r_state == S_SQI);
        o_cmd.sq_step  = (r_state == S_SQR);
        o_cmd.rt_init  = (r_state == S_RTI);
        o_cmd.rt_step  = (r_state == S_RT);
        o_cmd.dv_init  = (r_state == S_DVI);
        o_cmd.dv_step  = (r_state == S_DV);
        o_cmd.finish   = (r_state == S_FIN) && !i_sts.out_full;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_MAG;
            S_MAG:   if (i_sts.last) n_state = S_UPD;
            S_UPD:   n_state = S_MAC;
            S_MAC:   if (i_sts.last) n_state = S_SQI;
            S_SQI:   n_state = S_SQR;
            S_SQR:   if (i_sts.last) n_state = S_RTI;
            S_RTI:   n_state = S_RT;
            S_RT:    if (i_sts.last) n_state = S_DVI;
            S_DVI:   n_state = S_DV;
            S_DV:    if (i_sts.last) n_state = S_FIN;
            S_FIN:   if (!i_sts.out_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `NPC_ASSERT_NXT(a_accept_starts, (r_state == S_IDLE) && i_in_valid, r_state == S_MAG)
    `NPC_ASSERT_IMP(a_finish_free, o_cmd.finish, !i_sts.out_full)
    `NPC_ASSERT_NXT(a_div_to_fin, (r_state == S_DV) && i_sts.last, r_state == S_FIN)

endmodule

// ----- sv/normalized_preamble_correlator.sv -----
// Normalized chirp preamble correlator, top level.
// Channels: i_sample (sample_i/sample_q beats), o_result (metric, frame_start,
// delayed_i/delayed_q beats), i_cfg (register writes: 0 threshold, 1 data_length).
// All channels use valid/ready; a beat moves when both are high.
// Each sample is handled alone, in order: magnitude, window update, the
// single complex MAC (one tap a cycle), the bit-serial square, the
// two-bit-a-cycle square root and the one-bit-a-cycle divider.
// The next sample is taken as soon as the previous result sits in the output
// register; if the receiver stalls, that result holds and the sequencer waits
// at its final step, so at most one more sample is in flight.
// Reset (synchronous, active low) empties the window through a fill count,
// zeroes the magnitude sum and holdoff counter and restores the register
// defaults; no clearing pass is needed. Register writes are always ready.
// Depends on npc_pkg, npc_if, npc_dp and npc_ctrl.

module normalized_preamble_correlator import npc_pkg::*; #(
    parameter int SEQ_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    npc_in_if.sink     i_sample,
    npc_cfg_if.sink    i_cfg,
    npc_out_if.source  o_result
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_sample.ready = w_in_ready;

    npc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    npc_dp #(
        .SEQ_LEN (SEQ_LEN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_sample_i (i_sample.sample_i),
        .i_sample_q (i_sample.sample_q),
        .i_cfg      (i_cfg),
        .o_result   (o_result)
    );

endmodule
